// ===== hw/rtl/wrr_pkg.sv =====
// Shared constants, codes and transaction types of the windowed reorder receiver.
package wrr_pkg;

    localparam int WINDOW_DEPTH = 4;
    localparam int SEQ_SPACE    = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int SEQ_BITS  = $clog2(SEQ_SPACE);
    localparam int SLOT_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
    localparam int ACK_BITS  = SEQ_BITS + 1;

    localparam logic signed [ACK_BITS-1:0] ACK_NONE = -ACK_BITS'(1);

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    typedef struct packed {
        logic                    checksum_ok;
        logic [SEQ_BITS-1:0]     seq_num;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_in_item;

    typedef struct packed {
        logic                       kind;
        logic [PAYLOAD_BITS-1:0]    data_out;
        logic signed [ACK_BITS-1:0] ack_num;
        logic                       last;
    } t_out_item;

endpackage

// ===== hw/rtl/windowed_reorder_receiver_core.sv =====
// Receive window of a sliding-window transport: buffers, reorders, delivers and acknowledges.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one packet: checksum flag,
//   sequence number and payload word. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns zero or more in-order deliveries (kind 0) followed by exactly one
//   ACK (kind 1, last set) carrying the cumulative ACK number, -1 before any delivery.
//   One packet is in flight at a time; o_in_ready is high only while the sequencer idles.
//   A packet that delivers nothing goes from the check step straight to the ACK step; a
//   packet at the window base passes a scan and an emit step per released word and a
//   last scan step that slides the base before its ACK step.
//   The steps are set by the sequencer: one shared 3-bit adder computes the window
//   offset, the new base and the ACK number in turn, and the payload store is a RAM
//   read once per delivered word.
//   The last result sits in an output register, so the next packet is accepted while the
//   ACK still waits for the receiver. When the receiver stalls, the sequencer holds in its
//   emit or ACK step with no state change until the output register frees.
//   Reset (synchronous, active low) empties the window, sets the base to 0 and the
//   ACK number to -1. Buffered payload words are not cleared; their valid flags are.
module windowed_reorder_receiver_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wrr_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wrr_pkg::t_out_item o_out_data
);
    import wrr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_ACK   = 3'd4;

    logic [2:0]                 r_state,    n_state;
    t_in_item                   r_item,     n_item;
    logic [WINDOW_DEPTH-1:0]    r_valid,    n_valid;
    logic [SEQ_BITS-1:0]        r_base,     n_base;
    logic signed [ACK_BITS-1:0] r_last_ack, n_last_ack;
    logic                       r_adv,      n_adv;
    logic [CNT_BITS-1:0]        r_cnt,      n_cnt;
    logic [SLOT_BITS-1:0]       r_scan,     n_scan;
    t_out_item                  r_out,      n_out;
    logic                       r_out_valid, n_out_valid;

    // shared adder
    logic [SEQ_BITS-1:0] w_add_a, w_add_b, w_sum;
    logic                w_add_cin;

    logic                    w_out_free;
    logic                    w_wr_en, w_rd_en;
    logic [SLOT_BITS-1:0]    w_wr_addr;
    logic [PAYLOAD_BITS-1:0] w_rd_data;
    logic                    w_in_window;
    logic                    w_slot_live;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_wr_addr  = SLOT_BITS'(r_item.seq_num);

    always_comb begin
        w_add_a   = '0;
        w_add_b   = '0;
        w_add_cin = 1'b0;
        unique case (r_state)
            S_CHECK: begin
                // offset = seq - base, modulo the sequence space
                w_add_a   = r_item.seq_num;
                w_add_b   = ~r_base;
                w_add_cin = 1'b1;
            end
            S_SCAN: begin
                w_add_a = r_base;
                w_add_b = SEQ_BITS'(r_cnt);
            end
            S_ACK: begin
                w_add_a = r_base;
                w_add_b = '1;
            end
            default: begin
                w_add_a   = '0;
                w_add_b   = '0;
                w_add_cin = 1'b0;
            end
        endcase
        w_sum = SEQ_BITS'(w_add_a + w_add_b + SEQ_BITS'(w_add_cin));
    end

    assign w_in_window = r_item.checksum_ok && (32'(w_sum) < WINDOW_DEPTH);
    assign w_slot_live = (32'(r_cnt) < WINDOW_DEPTH) && r_valid[r_scan];

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_valid     = r_valid;
        n_base      = r_base;
        n_last_ack  = r_last_ack;
        n_adv       = r_adv;
        n_cnt       = r_cnt;
        n_scan      = r_scan;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_adv = 1'b0;
                if (w_in_window) begin
                    w_wr_en            = 1'b1;
                    n_valid[w_wr_addr] = 1'b1;
                end
                if (w_in_window && w_sum == '0) begin
                    n_adv   = 1'b1;
                    n_cnt   = '0;
                    n_scan  = SLOT_BITS'(r_base);
                    n_state = S_SCAN;
                end else begin
                    n_state = S_ACK;
                end
            end
            S_SCAN: begin
                if (w_slot_live) begin
                    w_rd_en = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    // slide the window past the delivered run
                    n_base  = w_sum;
                    n_state = S_ACK;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out.kind      = KIND_DELIVER;
                    n_out.data_out  = w_rd_data;
                    n_out.ack_num   = '0;
                    n_out.last      = 1'b0;
                    n_out_valid     = 1'b1;
                    n_valid[r_scan] = 1'b0;
                    n_scan          = SLOT_BITS'(r_scan + 1'b1);
                    n_cnt           = CNT_BITS'(r_cnt + 1'b1);
                    n_state         = S_SCAN;
                end
            end
            S_ACK: begin
                if (w_out_free) begin
                    if (r_adv) begin
                        n_last_ack = $signed({1'b0, w_sum});
                    end
                    n_out.kind     = KIND_ACK;
                    n_out.data_out = '0;
                    n_out.ack_num  = r_adv ? $signed({1'b0, w_sum}) : r_last_ack;
                    n_out.last     = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_base      <= '0;
            r_last_ack  <= ACK_NONE;
            r_adv       <= 1'b0;
            r_cnt       <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_base      <= n_base;
            r_last_ack  <= n_last_ack;
            r_adv       <= n_adv;
            r_cnt       <= n_cnt;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
    end

    // slot index is the sequence number modulo the window depth
    wrr_ram #(
        .WIDTH(PAYLOAD_BITS),
        .DEPTH(WINDOW_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (r_item.payload),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_scan),
        .o_rd_data (w_rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/wrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/wrr_checker.sv =====
// Port-level assertions for the windowed reorder receiver, bound to the top level.
module wrr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input wrr_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input wrr_pkg::t_out_item o_out_data
);
    import wrr_pkg::*;

    // one packet in flight: ready drops right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a packet was in flight");

    // ready returns only together with the ACK of the previous packet
    a_ready_with_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_ready) |-> (o_out_valid && o_out_data.kind == KIND_ACK))
        else $error("input ready returned without an ACK");

    a_last_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.kind == KIND_ACK) == o_out_data.last))
        else $error("last flag does not mark the ACK");

    a_field_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.kind == KIND_ACK && o_out_data.data_out == '0) ||
                         (o_out_data.kind == KIND_DELIVER && o_out_data.ack_num == '0)))
        else $error("unused result field not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transaction changed");

endmodule

bind windowed_reorder_receiver_core wrr_checker u_wrr_checker (.*);
